// ===== rtl/core/dcbd_pkg.sv =====
package dcbd_pkg;

    localparam int DICT_ENTRIES     = 32;
    localparam int DICT_IDX_W       = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int LONG_CHUNK_BYTES = 1024;

    localparam int LEN_FIELD_BITS   = 10;
    localparam int DCOUNT_BITS      = 6;
    localparam int RCOUNT_BITS      = 3;
    localparam int CODE_BITS        = 2;
    localparam int BYTE_BITS        = 8;

    localparam int SHIFT_W          = 10;
    localparam int BITS_LEFT_W      = 4;
    localparam int BYTES_LEFT_W     = 11;

    typedef enum logic {
        FUNC_STREAM = 1'b0,
        FUNC_LOAD   = 1'b1
    } t_func;

    typedef struct packed {
        t_func       func;
        logic        bit_in;
        logic [4:0]  entry_index;
        logic [7:0]  entry_byte;
        logic [1:0]  entry_code;
        logic [2:0]  entry_length;
        logic [3:0]  entry_payload;
    } t_in;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_buffer;
    } t_out;

    typedef struct packed {
        logic                  en;
        logic [DICT_IDX_W-1:0] index;
        logic [7:0]            value;
        logic [1:0]            code;
        logic                  live;
        logic [3:0]            payload;
    } t_dict_wr;

    typedef struct packed {
        logic [1:0]  code;
        logic [3:0]  payload;
    } t_dict_look;

    typedef struct packed {
        logic        found;
        logic [7:0]  value;
    } t_dict_hit;

endpackage

// ===== rtl/core/dcbd_dict.sv =====
module dcbd_dict import dcbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dict_wr   i_wr,
    input  t_dict_look i_look,
    output t_dict_hit  o_hit
);

    logic [7:0]              r_value   [DICT_ENTRIES];
    logic [1:0]              r_code    [DICT_ENTRIES];
    logic [3:0]              r_payload [DICT_ENTRIES];
    logic [DICT_ENTRIES-1:0] r_live;

    logic [DICT_ENTRIES-1:0] w_hit;
    logic [DICT_ENTRIES-1:0] w_term;
    logic [DICT_ENTRIES-1:0] w_first;
    logic [DICT_ENTRIES-1:0] w_sel;
    logic [7:0]              w_value;

    // a slot is live once written with a non-zero length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (i_wr.en) begin
            r_live[i_wr.index] <= i_wr.live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_value[i_wr.index]   <= i_wr.value;
            r_code[i_wr.index]    <= i_wr.code;
            r_payload[i_wr.index] <= i_wr.payload;
        end
    end

    // first slot that either matches or ends the dictionary
    always_comb begin
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            w_hit[i] = r_live[i] && (r_code[i] == i_look.code)
                       && (r_payload[i] == i_look.payload);
        end
        w_term  = w_hit | ~r_live;
        w_first = w_term & (~w_term + DICT_ENTRIES'(1));
        w_sel   = w_first & w_hit;
        w_value = '0;
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            w_value = w_value | ({8{w_sel[i]}} & r_value[i]);
        end
    end

    assign o_hit.found = |w_sel;
    assign o_hit.value = w_value;

endmodule

// ===== rtl/core/dictionary_chunk_buffer_decoder.sv =====
// Bit-serial buffer decoder. Each input item is either one coded stream bit
// (func = 0) or a dictionary slot write (func = 1); slot writes do not disturb
// the parse. The first bit of a buffer selects chunked or compressed mode, and
// every chunk or run begins with a continue bit whose 0 gives an end-of-buffer
// item. Items are taken one per clock while the input is not stalled: an item
// is held in the input register, parsed and matched against all dictionary
// slots in parallel in a single pass, and its result, if any, leaves from the
// output register. The input channel stalls only while the output register
// holds an item that is stalled.
module dictionary_chunk_buffer_decoder import dcbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_item
);

    typedef enum logic [3:0] {
        PH_MODE,
        PH_CONT,
        PH_KIND,
        PH_LEN10,
        PH_BYTE,
        PH_RCOUNT,
        PH_DCOUNT,
        PH_CODE,
        PH_PAYLOAD
    } t_phase;

    logic                    r_in_vld;
    t_in                     r_in;
    logic                    r_out_vld;
    t_out                    r_out;

    t_phase                  r_phase,      n_phase;
    logic                    r_cmode,      n_cmode;
    logic [SHIFT_W-1:0]      r_shift,      n_shift;
    logic [BITS_LEFT_W-1:0]  r_field_left, n_field_left;
    logic [BYTES_LEFT_W-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]              r_rcode,      n_rcode;
    logic [7:0]              r_last,       n_last;
    t_out                    n_out;

    logic                    w_adv;
    logic                    w_proc;
    logic                    w_emit;
    logic [SHIFT_W-1:0]      w_field;
    logic [BITS_LEFT_W-1:0]  w_left;
    logic [BYTES_LEFT_W-1:0] w_bytes_dec;
    t_dict_wr                w_wr;
    t_dict_look              w_look;
    t_dict_hit               w_hit;

    assign w_adv   = !r_out_vld || !i_stall;
    assign w_proc  = r_in_vld && w_adv;
    assign o_stall = r_in_vld && !w_adv;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    assign w_field     = {r_shift[SHIFT_W-2:0], r_in.bit_in};
    assign w_left      = (r_field_left != '0) ? r_field_left - BITS_LEFT_W'(1) : '0;
    assign w_bytes_dec = r_bytes_left - BYTES_LEFT_W'(1);

    assign w_wr.en      = w_proc && (r_in.func == FUNC_LOAD)
                          && (32'(r_in.entry_index) < DICT_ENTRIES);
    assign w_wr.index   = DICT_IDX_W'(r_in.entry_index);
    assign w_wr.value   = r_in.entry_byte;
    assign w_wr.code    = r_in.entry_code;
    assign w_wr.live    = (r_in.entry_length != '0);
    assign w_wr.payload = r_in.entry_payload;

    assign w_look.code    = r_rcode;
    assign w_look.payload = w_field[3:0];

    dcbd_dict u_dict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_look  (w_look),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_phase      = r_phase;
        n_cmode      = r_cmode;
        n_shift      = r_shift;
        n_field_left = r_field_left;
        n_bytes_left = r_bytes_left;
        n_rcode      = r_rcode;
        n_last       = r_last;
        n_out        = '0;
        w_emit       = 1'b0;
        if (w_proc && (r_in.func == FUNC_STREAM)) begin
            unique case (r_phase)
                PH_MODE: begin
                    n_cmode = r_in.bit_in;
                    n_last  = '0;
                    n_phase = PH_CONT;
                end
                PH_CONT: begin
                    if (!r_in.bit_in) begin
                        n_phase             = PH_MODE;
                        w_emit              = 1'b1;
                        n_out.end_of_buffer = 1'b1;
                    end else begin
                        n_phase = PH_KIND;
                    end
                end
                PH_KIND: begin
                    n_shift = '0;
                    if (r_cmode) begin
                        if (r_in.bit_in) begin
                            n_phase      = PH_DCOUNT;
                            n_field_left = BITS_LEFT_W'(DCOUNT_BITS);
                        end else begin
                            n_phase      = PH_RCOUNT;
                            n_field_left = BITS_LEFT_W'(RCOUNT_BITS);
                        end
                    end else if (r_in.bit_in) begin
                        n_bytes_left = BYTES_LEFT_W'(LONG_CHUNK_BYTES);
                        n_phase      = PH_BYTE;
                        n_field_left = BITS_LEFT_W'(BYTE_BITS);
                    end else begin
                        n_phase      = PH_LEN10;
                        n_field_left = BITS_LEFT_W'(LEN_FIELD_BITS);
                    end
                end
                PH_LEN10, PH_BYTE, PH_RCOUNT, PH_DCOUNT, PH_CODE, PH_PAYLOAD: begin
                    n_shift      = w_field;
                    n_field_left = w_left;
                    if (w_left == '0) begin
                        unique case (r_phase)
                            PH_LEN10: begin
                                n_bytes_left = BYTES_LEFT_W'(w_field);
                                if (w_field == '0) begin
                                    n_phase = PH_CONT;
                                end else begin
                                    n_phase      = PH_BYTE;
                                    n_shift      = '0;
                                    n_field_left = BITS_LEFT_W'(BYTE_BITS);
                                end
                            end
                            PH_RCOUNT: begin
                                n_bytes_left = BYTES_LEFT_W'(w_field) + BYTES_LEFT_W'(1);
                                n_phase      = PH_BYTE;
                                n_shift      = '0;
                                n_field_left = BITS_LEFT_W'(BYTE_BITS);
                            end
                            PH_DCOUNT: begin
                                n_bytes_left = BYTES_LEFT_W'(w_field) + BYTES_LEFT_W'(1);
                                n_phase      = PH_CODE;
                                n_shift      = '0;
                                n_field_left = BITS_LEFT_W'(CODE_BITS);
                            end
                            PH_CODE: begin
                                n_rcode      = w_field[1:0];
                                n_phase      = PH_PAYLOAD;
                                n_shift      = '0;
                                n_field_left = BITS_LEFT_W'(w_field[1:0]) + BITS_LEFT_W'(1);
                            end
                            PH_BYTE: begin
                                w_emit          = 1'b1;
                                n_out.data_byte = w_field[7:0];
                                n_bytes_left    = w_bytes_dec;
                                if (w_bytes_dec == '0) begin
                                    n_phase = PH_CONT;
                                end else begin
                                    n_shift      = '0;
                                    n_field_left = BITS_LEFT_W'(BYTE_BITS);
                                end
                            end
                            default: begin
                                // payload complete: dictionary record
                                w_emit          = 1'b1;
                                n_out.data_byte = w_hit.found ? w_hit.value : r_last;
                                if (w_hit.found) begin
                                    n_last = w_hit.value;
                                end
                                n_bytes_left = w_bytes_dec;
                                if (w_bytes_dec == '0) begin
                                    n_phase = PH_CONT;
                                end else begin
                                    n_phase      = PH_CODE;
                                    n_shift      = '0;
                                    n_field_left = BITS_LEFT_W'(CODE_BITS);
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_MODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_phase      <= PH_MODE;
            r_cmode      <= 1'b0;
            r_shift      <= '0;
            r_field_left <= '0;
            r_bytes_left <= '0;
            r_rcode      <= '0;
            r_last       <= '0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= w_proc && w_emit;
            end
            r_phase      <= n_phase;
            r_cmode      <= n_cmode;
            r_shift      <= n_shift;
            r_field_left <= n_field_left;
            r_bytes_left <= n_bytes_left;
            r_rcode      <= n_rcode;
            r_last       <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
        if (w_proc && w_emit) begin
            r_out <= n_out;
        end
    end

    a_end_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.end_of_buffer) |-> (o_item.data_byte == '0))
        else $error("end item carries a data byte");

    a_end_resets_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (r_in.func == FUNC_STREAM) && (r_phase == PH_CONT) && !r_in.bit_in)
        |=> (r_phase == PH_MODE))
        else $error("parse did not return to mode bit after stop bit");

    a_byte_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BYTE || r_phase == PH_PAYLOAD || r_phase == PH_CODE)
        |-> (r_bytes_left != '0))
        else $error("byte phase with no bytes left");

    a_field_bits_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BYTE || r_phase == PH_PAYLOAD || r_phase == PH_CODE
         || r_phase == PH_LEN10 || r_phase == PH_RCOUNT || r_phase == PH_DCOUNT)
        |-> (r_field_left != '0))
        else $error("field phase with no bits left");

endmodule

// ===== tb/dictionary_chunk_buffer_decoder_tb.sv =====
`timescale 1ns / 100ps

module dictionary_chunk_buffer_decoder_tb import dcbd_pkg::*; ();

    localparam int IN_W = $bits(t_in);
    localparam int REPORT_LIMIT = 50;

    typedef enum logic [3:0] {
        AWAIT_MODE,
        AWAIT_CONT,
        AWAIT_KIND,
        SHIFT_LEN,
        SHIFT_BYTE,
        SHIFT_RAW_COUNT,
        SHIFT_DICT_COUNT,
        SHIFT_CODE,
        SHIFT_PAYLOAD
    } t_parse;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_style;

    class buffer_decode_checker;
        t_parse      phase;
        bit          compressed;
        logic [9:0]  shift;
        logic [3:0]  bits_left;
        logic [10:0] bytes_left;
        logic [1:0]  rec_code;
        logic [7:0]  last_byte;
        logic [7:0]  dict_byte    [DICT_ENTRIES];
        logic [1:0]  dict_code    [DICT_ENTRIES];
        logic [2:0]  dict_len     [DICT_ENTRIES];
        logic [3:0]  dict_payload [DICT_ENTRIES];
        t_out        decoded_q [$];
        int          n_items;
        int          n_loads;
        int          n_bytes;
        int          n_ends;
        int          n_hits;
        int          n_misses;
        int          errors;

        function new();
            phase = AWAIT_MODE;
            compressed = 1'b0;
            shift = '0;
            bits_left = '0;
            bytes_left = '0;
            rec_code = '0;
            last_byte = '0;
            for (int i = 0; i < DICT_ENTRIES; i++) begin
                dict_byte[i] = '0;
                dict_code[i] = '0;
                dict_len[i] = '0;
                dict_payload[i] = '0;
            end
            n_items = 0;
            n_loads = 0;
            n_bytes = 0;
            n_ends = 0;
            n_hits = 0;
            n_misses = 0;
            errors = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void open_field(t_parse next, int nbits);
            phase = next;
            shift = '0;
            bits_left = 4'(nbits);
        endfunction

        function void report(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        endfunction

        function void note_item(t_in it);
            t_out       res;
            bit         emit;
            bit         found;
            logic [9:0] v;
            n_items++;
            if (it.func == FUNC_LOAD) begin
                dict_byte[it.entry_index] = it.entry_byte;
                dict_code[it.entry_index] = it.entry_code;
                dict_len[it.entry_index] = it.entry_length;
                dict_payload[it.entry_index] = it.entry_payload;
                n_loads++;
                return;
            end
            emit = 1'b0;
            res = '0;
            case (phase)
                AWAIT_MODE: begin
                    compressed = it.bit_in;
                    last_byte = '0;
                    phase = AWAIT_CONT;
                end
                AWAIT_CONT: begin
                    if (!it.bit_in) begin
                        phase = AWAIT_MODE;
                        res.end_of_buffer = 1'b1;
                        emit = 1'b1;
                        n_ends++;
                    end else begin
                        phase = AWAIT_KIND;
                    end
                end
                AWAIT_KIND: begin
                    if (compressed) begin
                        if (it.bit_in)
                            open_field(SHIFT_DICT_COUNT, DCOUNT_BITS);
                        else
                            open_field(SHIFT_RAW_COUNT, RCOUNT_BITS);
                    end else if (it.bit_in) begin
                        bytes_left = 11'(LONG_CHUNK_BYTES);
                        open_field(SHIFT_BYTE, BYTE_BITS);
                    end else begin
                        open_field(SHIFT_LEN, LEN_FIELD_BITS);
                    end
                end
                default: begin
                    shift = {shift[8:0], it.bit_in};
                    if (bits_left != 0)
                        bits_left--;
                    if (bits_left == 0) begin
                        v = shift;
                        case (phase)
                            SHIFT_LEN: begin
                                bytes_left = 11'(v);
                                if (v == 0)
                                    phase = AWAIT_CONT;
                                else
                                    open_field(SHIFT_BYTE, BYTE_BITS);
                            end
                            SHIFT_RAW_COUNT: begin
                                bytes_left = 11'(v + 1);
                                open_field(SHIFT_BYTE, BYTE_BITS);
                            end
                            SHIFT_DICT_COUNT: begin
                                bytes_left = 11'(v + 1);
                                open_field(SHIFT_CODE, CODE_BITS);
                            end
                            SHIFT_CODE: begin
                                rec_code = v[1:0];
                                open_field(SHIFT_PAYLOAD, rec_code + 1);
                            end
                            default: begin
                                if (phase == SHIFT_BYTE) begin
                                    res.data_byte = v[7:0];
                                end else begin
                                    // first live slot wins, an empty slot ends the search
                                    found = 1'b0;
                                    for (int i = 0; i < DICT_ENTRIES; i++) begin
                                        if (dict_len[i] == 0)
                                            break;
                                        if (dict_code[i] == rec_code
                                            && dict_payload[i] == v[3:0]) begin
                                            last_byte = dict_byte[i];
                                            found = 1'b1;
                                            break;
                                        end
                                    end
                                    if (found)
                                        n_hits++;
                                    else
                                        n_misses++;
                                    res.data_byte = last_byte;
                                end
                                emit = 1'b1;
                                n_bytes++;
                                bytes_left = 11'(bytes_left - 1);
                                if (bytes_left == 0)
                                    phase = AWAIT_CONT;
                                else if (phase == SHIFT_BYTE)
                                    open_field(SHIFT_BYTE, BYTE_BITS);
                                else
                                    open_field(SHIFT_CODE, CODE_BITS);
                            end
                        endcase
                    end
                end
            endcase
            if (emit)
                decoded_q.push_back(res);
        endfunction

        function void check_item(t_out got);
            t_out want;
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected item, expected none, %s %0h %0b",
                             $time, "actual data_byte and end_of_buffer",
                             got.data_byte, got.end_of_buffer);
                return;
            end
            want = decoded_q.pop_front();
            if (got.data_byte !== want.data_byte)
                report("data_byte", want.data_byte, got.data_byte);
            if (got.end_of_buffer !== want.end_of_buffer)
                report("end_of_buffer", 8'(want.end_of_buffer), 8'(got.end_of_buffer));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_item;
    logic o_valid;
    logic i_stall;
    t_out o_item;

    buffer_decode_checker decode_chk;
    int burst_left;
    bit loads_on;

    dictionary_chunk_buffer_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            decode_chk.check_item(o_item);
    end

    initial begin
        t_stall_style style;
        int           style_left;
        style = STALL_NONE;
        style_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (style_left == 0) begin
                style = t_stall_style'($urandom_range(0, 3));
                style_left = $urandom_range(16, 128);
            end
            style_left--;
            case (style)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_stall <= (style_left % 5 < 3);
                default:        i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic push_item(input t_in it);
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        decode_chk.note_item(it);
    endtask

    task automatic load_entry(input logic [4:0] idx, input logic [7:0] value,
                              input logic [1:0] code, input logic [2:0] len,
                              input logic [3:0] payload);
        t_in it;
        it = IN_W'($urandom);
        it.func = FUNC_LOAD;
        it.entry_index = idx;
        it.entry_byte = value;
        it.entry_code = code;
        it.entry_length = len;
        it.entry_payload = payload;
        push_item(it);
    endtask

    task automatic stream_bit(input logic b);
        t_in it;
        if (loads_on && $urandom_range(0, 49) == 0)
            load_entry(5'($urandom), 8'($urandom), 2'($urandom),
                       3'($urandom_range(0, 4)), 4'($urandom));
        it = IN_W'($urandom);
        it.func = FUNC_STREAM;
        it.bit_in = b;
        push_item(it);
    endtask

    task automatic stream_field(input logic [9:0] value, input int nbits);
        for (int k = nbits - 1; k >= 0; k--)
            stream_bit(value[k]);
    endtask

    task automatic stream_byte();
        int         r;
        logic [7:0] value;
        r = $urandom_range(0, 9);
        value = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        stream_field(10'(value), BYTE_BITS);
    endtask

    task automatic reload_dictionary();
        int         n;
        logic [1:0] code;
        n = ($urandom_range(0, 5) == 0) ? DICT_ENTRIES : $urandom_range(1, 8);
        for (int s = 0; s < n; s++) begin
            code = 2'($urandom);
            load_entry(5'(s), 8'($urandom), code, 3'($urandom_range(1, 4)),
                       4'($urandom_range(0, (2 << code) - 1)));
        end
        if (n < DICT_ENTRIES)
            load_entry(5'(n), 8'($urandom), 2'($urandom), 3'd0, 4'($urandom));
    endtask

    task automatic scramble();
        int   n;
        logic b;
        n = $urandom_range(1, 12);
        // keep noise out of long chunks and long chunk lengths
        repeat (n) begin
            b = 1'($urandom);
            if (decode_chk.phase == SHIFT_LEN ||
                (decode_chk.phase == AWAIT_KIND && !decode_chk.compressed))
                b = 1'b0;
            stream_bit(b);
        end
        while (decode_chk.phase != AWAIT_MODE) begin
            if (decode_chk.phase inside {AWAIT_CONT, AWAIT_KIND, SHIFT_LEN})
                stream_bit(1'b0);
            else
                stream_bit(1'($urandom));
        end
    endtask

    task automatic close_buffer();
        if ($urandom_range(0, 9) == 0)
            scramble();
        else
            stream_bit(1'b0);
    endtask

    task automatic chunked_buffer();
        int chunks;
        int n;
        chunks = $urandom_range(0, 3);
        stream_bit(1'b0);
        repeat (chunks) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
            stream_bit(1'b1);
            stream_bit(1'b0);
            stream_field(10'(n), LEN_FIELD_BITS);
            repeat (n) stream_byte();
        end
        close_buffer();
    endtask

    task automatic compressed_buffer();
        int         runs;
        int         cnt;
        int         live;
        int         pick;
        logic [1:0] code;
        logic [3:0] payload;
        runs = $urandom_range(0, 4);
        stream_bit(1'b1);
        repeat (runs) begin
            stream_bit(1'b1);
            if ($urandom_range(0, 2) == 0) begin
                cnt = $urandom_range(1, 8);
                stream_bit(1'b0);
                stream_field(10'(cnt - 1), RCOUNT_BITS);
                repeat (cnt) stream_byte();
            end else begin
                cnt = ($urandom_range(0, 15) == 0) ? 64 : $urandom_range(1, 6);
                stream_bit(1'b1);
                stream_field(10'(cnt - 1), DCOUNT_BITS);
                repeat (cnt) begin
                    live = 0;
                    while (live < DICT_ENTRIES && decode_chk.dict_len[live] != 0)
                        live++;
                    code = 2'($urandom);
                    payload = 4'($urandom_range(0, (2 << code) - 1));
                    // mostly aim at a live slot so that records match
                    if (live > 0 && $urandom_range(0, 3) != 0) begin
                        pick = $urandom_range(0, live - 1);
                        if (decode_chk.dict_payload[pick] < (2 << decode_chk.dict_code[pick])) begin
                            code = decode_chk.dict_code[pick];
                            payload = decode_chk.dict_payload[pick];
                        end
                    end
                    stream_field(10'(code), CODE_BITS);
                    stream_field(10'(payload), code + 1);
                end
            end
        end
        close_buffer();
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (decode_chk.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        #4_000_000;
        $display("timeout waiting for the decoder");
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int start_items;
        int waited;
        decode_chk = new();
        burst_left = 0;
        loads_on = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widest slot at the bottom, all-zero terminator at the top
        load_entry(5'd0, 8'hFF, 2'd3, 3'd4, 4'hF);
        load_entry(5'd31, 8'h00, 2'd0, 3'd0, 4'h0);
        // dictionary run: miss before any match, hit, miss repeating the hit
        stream_bit(1'b1);
        stream_bit(1'b1);
        stream_bit(1'b1);
        stream_field(10'd2, DCOUNT_BITS);
        stream_field(10'd0, CODE_BITS);
        stream_field(10'd0, 1);
        stream_field(10'd3, CODE_BITS);
        stream_field(10'hF, 4);
        stream_field(10'd0, CODE_BITS);
        stream_field(10'd1, 1);
        stream_bit(1'b0);
        // empty chunked buffer
        stream_bit(1'b0);
        stream_bit(1'b0);
        pause_until_drained();

        loads_on = 1'b1;
        reload_dictionary();
        start_items = decode_chk.n_items;
        while (decode_chk.n_items - start_items < 1150) begin
            if ($urandom_range(0, 11) == 0)
                reload_dictionary();
            if ($urandom_range(0, 19) == 0)
                pause_until_drained();
            case ($urandom_range(0, 9))
                0, 1:    scramble();
                2, 3, 4: chunked_buffer();
                default: compressed_buffer();
            endcase
        end

        i_valid <= 1'b0;
        for (waited = 0; waited < 5000 && decode_chk.pending() != 0; waited++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (decode_chk.pending() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, decode_chk.pending());
            decode_chk.errors += decode_chk.pending();
        end

        $display("run covered %0d items with %0d dictionary writes,",
                 decode_chk.n_items, decode_chk.n_loads);
        $display("checking %0d bytes and %0d end markers; %0d records matched, %0d repeated",
                 decode_chk.n_bytes, decode_chk.n_ends, decode_chk.n_hits, decode_chk.n_misses);
        if (decode_chk.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== dictionary_chunk_buffer_decoder.f =====
rtl/core/dcbd_pkg.sv
rtl/core/dcbd_dict.sv
rtl/core/dictionary_chunk_buffer_decoder.sv
tb/dictionary_chunk_buffer_decoder_tb.sv
